// ----- design/lifeg_pkg.sv -----
// shared types and constants for the life grid generation engine
// no dependencies; imported by lifeg_cell and the top level

package lifeg_pkg;

	// vertical count of one column of the three-row window, 0..3
	localparam int VSUM_W = 2;
	// full neighbour count, 0..8
	localparam int NBR_W  = 4;

	typedef logic [VSUM_W-1:0] vsum_t;
	typedef logic [NBR_W-1:0]  nbr_t;

	// b3/s23 rule counts
	localparam nbr_t BIRTH_COUNT   = nbr_t'(3);
	localparam nbr_t SURVIVE_COUNT = nbr_t'(2);

	// control from the sequencer to every cell of the row
	typedef struct packed {
		logic clear;   // empty the window at the start of a sweep
		logic shift;   // move the window down by one row
	} cell_ctrl_t;

	// per-cell result of the rule
	typedef struct packed {
		logic nxt;     // next-generation bit (old bit for columns out of use)
		logic diff;    // in-use cell flips
	} cell_stat_t;

endpackage

// ----- design/lifeg_mem.sv -----
// world storage: one row of cells per entry, one write and one read port
// read data is registered; no dependencies

module lifeg_mem #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

endmodule

// ----- design/lifeg_cell.sv -----
// one column cell: holds the above/current/below bits of its column
// depends on lifeg_pkg; trades vertical counts with both neighbours

module lifeg_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  lifeg_pkg::cell_ctrl_t ctrl,
	input  logic                  feed,
	input  logic                  inuse,
	input  lifeg_pkg::vsum_t      left_vsum,
	input  lifeg_pkg::vsum_t      right_vsum,
	output lifeg_pkg::vsum_t      vsum,
	output lifeg_pkg::cell_stat_t stat
);
	import lifeg_pkg::*;

	logic above_q;
	logic cur_q;
	logic below_q;
	nbr_t cnt;
	logic rule;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			above_q <= 1'b0;
			cur_q   <= 1'b0;
			below_q <= 1'b0;
		end else if (ctrl.clear) begin
			above_q <= 1'b0;
			cur_q   <= 1'b0;
			below_q <= 1'b0;
		end else if (ctrl.shift) begin
			above_q <= cur_q;
			cur_q   <= below_q;
			below_q <= feed;
		end
	end

	// columns out of use count as dead for the neighbours
	assign vsum = inuse ? (vsum_t'(above_q) + vsum_t'(cur_q) + vsum_t'(below_q)) : '0;

	assign cnt  = nbr_t'(left_vsum) + nbr_t'(right_vsum) + nbr_t'(above_q) + nbr_t'(below_q);
	assign rule = (cnt == BIRTH_COUNT) || (cur_q && (cnt == SURVIVE_COUNT));

	assign stat.nxt  = inuse ? rule : cur_q;
	assign stat.diff = inuse && (rule != cur_q);

endmodule

// ----- design/life_grid_generation_engine.sv -----
// top level of the life grid generation engine (b3/s23)
// depends on lifeg_pkg, lifeg_mem and lifeg_cell
//
// channel | dir | handshake         | content
// --------+-----+-------------------+------------------------------------------
// s_      | in  | s_tvalid/s_tready | s_tdata: mode[1:0] row[7:2] col[13:8] alive[14]
// m_      | out | m_tvalid/m_tready | m_tdata: cell_value[0] changed[1] out_of_range[2]
// cfg_    | in  | cfg_we            | cfg_index 0 height, 1 width; cfg_data 7 bits
//
// sequence: a cell write or read goes through ST_ACCESS, where the registered row
//   read is back, then ST_DONE; coordinates outside the area or the unused mode go
//   straight to ST_DONE; a generation step sweeps the rows in use through the world
//   memory read port and the row of column cells, which take one row per cycle
// reset: arst_n clears control, valid bits and config (64 by 64); the world reads
//   as all dead through per-row valid bits, so no clearing pass is needed
// stalls: one transaction is worked on at a time; a finished result waits in the
//   output register while the next transaction is accepted

module life_grid_generation_engine #(
	parameter int MAX_ROWS = 64,
	parameter int MAX_COLS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // mode[1:0], row[7:2], col[13:8], alive[14], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,   // cell_value[0], changed[1], out_of_range[2], zero pad
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data
);
	import lifeg_pkg::*;

	localparam int AW = $clog2(MAX_ROWS);
	localparam int HW = $clog2(MAX_ROWS + 1);
	localparam int CW = $clog2(MAX_COLS);
	localparam int WW = $clog2(MAX_COLS + 1);

	localparam logic REG_HEIGHT = 1'b0;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_STEP  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_SWEEP,
		ST_DRAIN,
		ST_DONE
	} state_t;

	// input fields
	mode_t      in_mode;
	logic [5:0] in_row;
	logic [5:0] in_col;
	logic       in_alive;

	// configuration
	logic [6:0]    height_q;
	logic [6:0]    width_q;
	logic [HW-1:0] eff_h;
	logic [WW-1:0] eff_w;

	// sequencer
	state_t        state_q;
	mode_t         mode_q;
	logic [AW-1:0] row_q;
	logic [CW-1:0] col_q;
	logic          alive_q;
	logic [HW-1:0] k_q;
	logic          res_cell_q;
	logic          res_chg_q;
	logic          res_oor_q;
	logic          m_tvalid_q;
	logic [2:0]    m_data_q;
	logic          accept;
	logic          in_area;

	// sweep pipeline
	logic          feed_s1;
	logic          zero_s1;
	logic [HW-1:0] k_s1;
	logic          comp_s2;
	logic [AW-1:0] row_s2;
	logic          diff_q;

	// memory and valid bits
	logic [MAX_ROWS-1:0] row_valid_q;
	logic                rd_valid_q;
	logic                mem_we;
	logic [AW-1:0]       mem_waddr;
	logic [MAX_COLS-1:0] mem_wdata;
	logic [AW-1:0]       mem_raddr;
	logic [MAX_COLS-1:0] mem_rdata;
	logic [MAX_COLS-1:0] row_data;
	logic [MAX_COLS-1:0] rmw_data;

	// cell row
	cell_ctrl_t          cell_ctrl;
	vsum_t               vsum [MAX_COLS];
	cell_stat_t          stat [MAX_COLS];
	logic [MAX_COLS-1:0] inuse;
	logic [MAX_COLS-1:0] feed_row;
	logic [MAX_COLS-1:0] nxt_row;
	logic [MAX_COLS-1:0] diff_row;

	assign in_mode  = mode_t'(s_tdata[1:0]);
	assign in_row   = s_tdata[7:2];
	assign in_col   = s_tdata[13:8];
	assign in_alive = s_tdata[14];

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= 7'd64;
			width_q  <= 7'd64;
		end else if (cfg_we) begin
			if (cfg_index == REG_HEIGHT) begin
				height_q <= cfg_data;
			end else begin
				width_q <= cfg_data;
			end
		end
	end

	// sizes above the build limits saturate
	assign eff_h = (32'(height_q) > MAX_ROWS) ? HW'(MAX_ROWS) : HW'(height_q);
	assign eff_w = (32'(width_q) > MAX_COLS) ? WW'(MAX_COLS) : WW'(width_q);

	assign in_area = (32'(in_row) < 32'(eff_h)) && (32'(in_col) < 32'(eff_w));

	// ------------------------------------------------------------ handshakes
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'd0, m_data_q};

	// ------------------------------------------------------- sequencer + output
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			mode_q     <= MODE_WRITE;
			row_q      <= '0;
			col_q      <= '0;
			alive_q    <= 1'b0;
			k_q        <= '0;
			res_cell_q <= 1'b0;
			res_chg_q  <= 1'b0;
			res_oor_q  <= 1'b0;
			m_tvalid_q <= 1'b0;
			m_data_q   <= '0;
		end else begin
			// in ST_DONE the output register is reloaded instead
			if (m_tvalid_q && m_tready && (state_q != ST_DONE)) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						mode_q     <= in_mode;
						row_q      <= AW'(in_row);
						col_q      <= CW'(in_col);
						alive_q    <= in_alive;
						k_q        <= '0;
						res_cell_q <= 1'b0;
						res_chg_q  <= 1'b0;
						case (in_mode)
							MODE_WRITE, MODE_READ: begin
								res_oor_q <= !in_area;
								if (in_area) begin
									state_q <= ST_ACCESS;
								end else begin
									state_q <= ST_DONE;
								end
							end
							MODE_STEP: begin
								res_oor_q <= 1'b0;
								state_q   <= ST_SWEEP;
							end
							default: begin
								// unused mode: no effect, all-zero result
								res_oor_q <= 1'b0;
								state_q   <= ST_DONE;
							end
						endcase
					end
				end
				ST_ACCESS: begin
					// row data is back; a write updates the row this cycle
					if (mode_q == MODE_READ) begin
						res_cell_q <= row_data[col_q];
					end
					state_q <= ST_DONE;
				end
				ST_SWEEP: begin
					// rows 0..h-1 are read, then one empty row closes the window
					if (k_q == eff_h) begin
						state_q <= ST_DRAIN;
					end else begin
						k_q <= k_q + HW'(1);
					end
				end
				ST_DRAIN: begin
					if (!feed_s1 && !comp_s2) begin
						res_chg_q <= diff_q;
						state_q   <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						m_tvalid_q <= 1'b1;
						m_data_q   <= {res_oor_q, res_chg_q, res_cell_q};
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// --------------------------------------------------------- sweep pipeline
	// s1: row k arrives from memory and shifts into the window
	// s2: window is centered on row k-1, which is written back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			feed_s1 <= 1'b0;
			zero_s1 <= 1'b0;
			k_s1    <= '0;
			comp_s2 <= 1'b0;
			row_s2  <= '0;
			diff_q  <= 1'b0;
		end else begin
			feed_s1 <= (state_q == ST_SWEEP);
			zero_s1 <= (k_q == eff_h);
			k_s1    <= k_q;
			comp_s2 <= feed_s1 && (k_s1 != '0);
			row_s2  <= AW'(k_s1 - HW'(1));
			if (cell_ctrl.clear) begin
				diff_q <= 1'b0;
			end else if (comp_s2) begin
				diff_q <= diff_q | (|diff_row);
			end
		end
	end

	// ---------------------------------------------------------------- memory
	assign mem_raddr = (state_q == ST_IDLE) ? AW'(in_row) : AW'(k_q);

	always_comb begin
		rmw_data         = row_data;
		rmw_data[col_q]  = alive_q;
	end

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = row_q;
		mem_wdata = rmw_data;
		if (comp_s2) begin
			mem_we    = 1'b1;
			mem_waddr = row_s2;
			mem_wdata = nxt_row;
		end else if ((state_q == ST_ACCESS) && (mode_q == MODE_WRITE)) begin
			mem_we = 1'b1;
		end
	end

	// rows never written since reset read as all dead
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			rd_valid_q <= row_valid_q[mem_raddr];
			if (mem_we) begin
				row_valid_q[mem_waddr] <= 1'b1;
			end
		end
	end

	assign row_data = rd_valid_q ? mem_rdata : '0;

	lifeg_mem #(
		.DEPTH (MAX_ROWS),
		.WIDTH (MAX_COLS)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr   (mem_raddr),
		.rdata_q (mem_rdata)
	);

	// -------------------------------------------------------------- cell row
	assign cell_ctrl.clear = accept && (in_mode == MODE_STEP);
	assign cell_ctrl.shift = feed_s1;
	assign feed_row        = zero_s1 ? '0 : row_data;

	for (genvar c = 0; c < MAX_COLS; c++) begin : g_cell
		vsum_t lft;
		vsum_t rgt;

		if (c == 0) begin : g_left_edge
			assign lft = '0;
		end else begin : g_left
			assign lft = vsum[c-1];
		end
		if (c == MAX_COLS - 1) begin : g_right_edge
			assign rgt = '0;
		end else begin : g_right
			assign rgt = vsum[c+1];
		end

		assign inuse[c]    = (eff_w > WW'(c));
		assign nxt_row[c]  = stat[c].nxt;
		assign diff_row[c] = stat[c].diff;

		lifeg_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (cell_ctrl),
			.feed       (feed_row[c]),
			.inuse      (inuse[c]),
			.left_vsum  (lft),
			.right_vsum (rgt),
			.vsum       (vsum[c]),
			.stat       (stat[c])
		);
	end

	// ------------------------------------------------------------ assertions
	// writes only land inside the rows in use
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (32'(mem_waddr) < 32'(eff_h)))
		else $error("world write outside rows in use");

	// a write-back only follows a window shift
	assert property (@(posedge clk) disable iff (!arst_n)
		comp_s2 |-> $past(feed_s1))
		else $error("write-back without preceding row shift");

	// the read of a row ahead never hits the row being written back
	assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && (state_q == ST_SWEEP)) |-> (mem_raddr != mem_waddr))
		else $error("sweep read and write-back collide");

	// a new transaction is only taken with the sweep pipeline empty
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!feed_s1 && !comp_s2))
		else $error("accepting while sweep pipeline busy");

endmodule

// ----- bench/lifeg_tb_pkg.sv -----
// operation codes, register indexes and grid limits shared by the bench files
// no dependencies; imported by lifeg_checker and tb_life_grid_generation_engine
`timescale 1ns / 1ps

package lifeg_tb_pkg;

	typedef enum logic [1:0] {
		MODE_WRITE = 2'd0,
		MODE_READ  = 2'd1,
		MODE_STEP  = 2'd2,
		MODE_NONE  = 2'd3
	} mode_e;

	localparam logic REG_HEIGHT = 1'b0;
	localparam logic REG_WIDTH  = 1'b1;

	localparam int GRID_ROWS = 64;
	localparam int GRID_COLS = 64;

endpackage

// ----- bench/lifeg_checker.sv -----
// watches the command, result and config channels of the life grid engine,
// keeps its own copy of the grid and compares every result; uses lifeg_tb_pkg
`timescale 1ns / 1ps

module lifeg_checker
	import lifeg_tb_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [15:0] s_tdata,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [7:0]  m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [6:0]  cfg_data,
	output int          outstanding,
	output int          mismatches
);

	localparam int SURVIVE_LOW = 2;
	localparam int BIRTH_NBRS  = 3;

	typedef struct packed {
		logic cell_value;
		logic changed;
		logic out_of_range;
	} outcome_t;

	logic [63:0] grid [GRID_ROWS];
	logic [6:0]  rows_reg;
	logic [6:0]  cols_reg;
	outcome_t    pending_q [$];
	int          fail_total;

	function automatic int rows_used();
		return (rows_reg > GRID_ROWS) ? GRID_ROWS : int'(rows_reg);
	endfunction

	function automatic int cols_used();
		return (cols_reg > GRID_COLS) ? GRID_COLS : int'(cols_reg);
	endfunction

	// one generation over the area in use, old rows kept for the row above
	function automatic logic next_generation();
		int          eh, ew, r, c, n;
		logic [63:0] in_use, above, cur, below, nxt;
		logic        diff;
		eh = rows_used();
		ew = cols_used();
		in_use = (ew >= 64) ? '1 : ((64'd1 << ew) - 64'd1);
		above = '0;
		diff = 1'b0;
		for (r = 0; r < eh; r++) begin
			cur = grid[r] & in_use;
			below = (r + 1 < eh) ? (grid[r + 1] & in_use) : '0;
			nxt = '0;
			for (c = 0; c < ew; c++) begin
				n = int'(above[c]) + int'(below[c]);
				if (c + 1 < ew)
					n += int'(cur[c + 1]) + int'(above[c + 1]) + int'(below[c + 1]);
				if (c > 0)
					n += int'(cur[c - 1]) + int'(above[c - 1]) + int'(below[c - 1]);
				if ((cur[c] && (n == SURVIVE_LOW || n == BIRTH_NBRS)) || (!cur[c] && n == BIRTH_NBRS))
					nxt[c] = 1'b1;
			end
			if (nxt != cur)
				diff = 1'b1;
			grid[r] = (grid[r] & ~in_use) | nxt;
			above = cur;
		end
		return diff;
	endfunction

	function automatic outcome_t predict_outcome(logic [15:0] cmd);
		outcome_t   o;
		mode_e      md;
		logic [5:0] r, c;
		logic       in_area;
		o = '0;
		md = mode_e'(cmd[1:0]);
		r = cmd[7:2];
		c = cmd[13:8];
		in_area = (r < rows_used()) && (c < cols_used());
		case (md)
			MODE_WRITE: begin
				if (!in_area)
					o.out_of_range = 1'b1;
				else
					grid[r][c] = cmd[14];
			end
			MODE_READ: begin
				if (!in_area)
					o.out_of_range = 1'b1;
				else
					o.cell_value = grid[r][c];
			end
			MODE_STEP: o.changed = next_generation();
			default: ;
		endcase
		return o;
	endfunction

	task automatic compare_field(string name, logic want, logic got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %b actual %b", $time, name, want, got);
			fail_total++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < GRID_ROWS; i++)
				grid[i] = '0;
			rows_reg = 7'd64;
			cols_reg = 7'd64;
			pending_q.delete();
			fail_total = 0;
			outstanding <= 0;
			mismatches <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_HEIGHT: rows_reg = cfg_data;
					REG_WIDTH:  cols_reg = cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				if (pending_q.size() == 0) begin
					$display("%0t: unexpected result, expected none actual %h", $time, m_tdata);
					fail_total++;
				end else begin
					want = pending_q.pop_front();
					compare_field("cell_value", want.cell_value, m_tdata[0]);
					compare_field("changed", want.changed, m_tdata[1]);
					compare_field("out_of_range", want.out_of_range, m_tdata[2]);
					compare_field("pad", 1'b0, |m_tdata[7:3]);
				end
			end
			if (s_tvalid && s_tready)
				pending_q.push_back(predict_outcome(s_tdata));
			outstanding <= pending_q.size();
			mismatches <= fail_total;
		end
	end

endmodule

// ----- bench/tb_life_grid_generation_engine.sv -----
// stimulus and verdict for the life grid generation engine
// depends on lifeg_tb_pkg, lifeg_checker and the design files
`timescale 1ns / 1ps

module tb_life_grid_generation_engine;
	import lifeg_tb_pkg::*;

	// settle time after the final drain, to cover any tail activity
	localparam int SETTLE_CYCLES = 80;
	// far beyond the slowest legal run (~850 transactions, full-height steps, long stalls)
	localparam int TIMEOUT_NS    = 1_500_000;
	localparam int SEGMENTS      = 9;
	localparam int SEGMENT_ITEMS = 90;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [15:0] s_tdata;    // mode[1:0], row[7:2], col[13:8], alive[14], zero pad
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;    // cell_value[0], changed[1], out_of_range[2], zero pad
	logic        cfg_we;
	logic        cfg_index;
	logic [6:0]  cfg_data;

	int outstanding;
	int mismatches;

	// idle percentages of the two sides, moved on as transactions go by
	int send_idle_pct;
	int recv_idle_pct;
	int items_sent;

	// our view of the size registers, only used to aim coordinates
	logic [6:0] rows_set;
	logic [6:0] cols_set;

	life_grid_generation_engine i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	lifeg_checker i_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.mismatches  (mismatches)
	);

	always #1 clk = ~clk;

	// result side backpressure, random per cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	initial begin
		#(TIMEOUT_NS);
		$display("TEST FAILED");
		$finish;
	end

	// three idle regimes: slow receiver, slow sender, then full rate on both sides
	function automatic void update_idle();
		if (items_sent < 270) begin
			send_idle_pct = 34;
			recv_idle_pct = 80;
		end else if (items_sent < 540) begin
			send_idle_pct = 80;
			recv_idle_pct = 34;
		end else begin
			send_idle_pct = 0;
			recv_idle_pct = 0;
		end
	endfunction

	// one command transaction; tvalid stays high when the next follows at once
	task automatic send_item(input mode_e md, input logic [5:0] r, input logic [5:0] c,
			input logic a);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {1'b0, a, c, r, md};
		do
			@(posedge clk);
		while (!s_tready);
		if (md != MODE_NONE)
			items_sent++;
		update_idle();
	endtask

	// stop sending and wait for every predicted result to come back
	task automatic drain();
		s_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// size registers are only touched with the engine idle
	task automatic set_size(input logic [6:0] h, input logic [6:0] w);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= REG_HEIGHT;
		cfg_data <= h;
		@(posedge clk);
		cfg_index <= REG_WIDTH;
		cfg_data <= w;
		@(posedge clk);
		cfg_we <= 1'b0;
		rows_set = h;
		cols_set = w;
	endtask

	function automatic int used_dim(logic [6:0] v, int lim);
		return (v > lim) ? lim : int'(v);
	endfunction

	// coordinate close to a center, may step just past the area edge
	function automatic logic [5:0] near_coord(int centre, int lim);
		int v;
		if (lim == 0)
			return 6'($urandom);
		v = centre + int'($urandom_range(0, 4)) - 2;
		if (v < 0)
			v = 0;
		if (v > 63)
			v = 63;
		return 6'(v);
	endfunction

	// seed a small cluster, then let it evolve and probe around it
	task automatic run_pattern();
		int eh, ew, cr, cc;
		eh = used_dim(rows_set, GRID_ROWS);
		ew = used_dim(cols_set, GRID_COLS);
		cr = (eh > 0) ? $urandom_range(0, eh - 1) : 0;
		cc = (ew > 0) ? $urandom_range(0, ew - 1) : 0;
		repeat ($urandom_range(3, 10))
			send_item(MODE_WRITE, near_coord(cr, eh), near_coord(cc, ew),
				$urandom_range(0, 9) != 0);
		repeat ($urandom_range(1, 4)) begin
			send_item(MODE_STEP, 6'($urandom), 6'($urandom), 1'($urandom));
			repeat ($urandom_range(0, 3))
				send_item(MODE_READ, near_coord(cr, eh), near_coord(cc, ew), 1'($urandom));
		end
	endtask

	task automatic send_noise();
		send_item(mode_e'($urandom_range(0, 3)), 6'($urandom), 6'($urandom), 1'($urandom));
	endtask

	initial begin
		int target;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_we = 1'b0;
		cfg_index = REG_HEIGHT;
		cfg_data = '0;
		items_sent = 0;
		rows_set = 7'd64;
		cols_set = 7'd64;
		update_idle();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners of the full grid, a blinker, the unused mode
		send_item(MODE_WRITE, 6'd0, 6'd0, 1'b1);
		send_item(MODE_WRITE, 6'd63, 6'd63, 1'b1);
		send_item(MODE_WRITE, 6'd0, 6'd63, 1'b1);
		send_item(MODE_WRITE, 6'd63, 6'd0, 1'b1);
		send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
		send_item(MODE_READ, 6'd63, 6'd63, 1'b1);
		send_item(MODE_WRITE, 6'd10, 6'd20, 1'b1);
		send_item(MODE_WRITE, 6'd10, 6'd21, 1'b1);
		send_item(MODE_WRITE, 6'd10, 6'd22, 1'b1);
		send_item(MODE_STEP, 6'd0, 6'd0, 1'b0);
		send_item(MODE_READ, 6'd9, 6'd21, 1'b0);
		send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
		send_item(MODE_NONE, 6'd63, 6'd63, 1'b1);
		send_item(MODE_STEP, 6'd63, 6'd63, 1'b1);
		send_item(MODE_WRITE, 6'd10, 6'd21, 1'b0);
		send_item(MODE_STEP, 6'd0, 6'd0, 1'b0);

		// small area: edges, accesses past it, single cell dying, then a still grid
		set_size(7'd5, 7'd5);
		send_item(MODE_WRITE, 6'd5, 6'd0, 1'b1);
		send_item(MODE_READ, 6'd0, 6'd5, 1'b0);
		send_item(MODE_WRITE, 6'd4, 6'd4, 1'b1);
		send_item(MODE_READ, 6'd4, 6'd4, 1'b0);
		send_item(MODE_STEP, 6'd0, 6'd0, 1'b0);
		send_item(MODE_STEP, 6'd0, 6'd0, 1'b0);

		// empty area, then oversized registers clamp and expose the untouched cells
		set_size(7'd0, 7'd0);
		send_item(MODE_READ, 6'd0, 6'd0, 1'b0);
		send_item(MODE_STEP, 6'd0, 6'd0, 1'b0);
		set_size(7'd127, 7'd127);
		send_item(MODE_READ, 6'd10, 6'd20, 1'b0);
		send_item(MODE_READ, 6'd63, 6'd63, 1'b0);

		// random: mostly seeded clusters, some stray commands, a new size per segment
		for (int seg = 0; seg < SEGMENTS; seg++) begin
			case (seg)
				0: set_size(7'd64, 7'd64);
				1: set_size(7'd2, 7'd2);
				2: set_size(7'd127, 7'd65);
				3: set_size(7'd1, 7'd64);
				4: set_size(7'd64, 7'd1);
				5: set_size(7'd0, 7'd7);
				6: set_size(7'($urandom_range(2, 16)), 7'($urandom_range(2, 64)));
				default: set_size(7'($urandom_range(2, 64)), 7'($urandom_range(2, 64)));
			endcase
			target = items_sent + SEGMENT_ITEMS;
			while (items_sent < target) begin
				if ($urandom_range(99) < 70)
					run_pattern();
				else
					send_noise();
			end
		end

		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/lifeg_pkg.sv
design/lifeg_mem.sv
design/lifeg_cell.sv
design/life_grid_generation_engine.sv
bench/lifeg_tb_pkg.sv
bench/lifeg_checker.sv
bench/tb_life_grid_generation_engine.sv
